FILE: rtl/mns_pkg.sv
package mns_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int COUNT_W     = 6;
  localparam int MIN_SAMPLES = 3;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd3;

  // position and index fields cover blocks of up to 256 samples
  localparam int POS_W = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified sample on its way from front to back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]           pos;   // samples already held in the block
    logic [POS_W-1:0]           idx;   // median index, valid with last
    logic                       last;  // this sample completes the block
  } mns_word_t;

endpackage

FILE: rtl/mns_front.sv
module mns_front #(
  parameter int MAX_SAMPLES = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [mns_pkg::COUNT_W-1:0]         cfg_wr_data,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  logic signed [mns_pkg::SAMPLE_W-1:0] sample,
  input  logic                                q_full,
  output logic                                q_push,
  output mns_pkg::mns_word_t                  q_word
);
  import mns_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic [COUNT_W-1:0] sample_count;
  logic [CW-1:0]      filled;
  logic [CW-1:0]      filled_next;
  logic [CW-1:0]      n_eff;
  logic [CW-1:0]      pos;
  logic [CW-1:0]      pos_inc;
  logic               last;

  // clamp the configured count to the supported range
  always_comb begin
    if (sample_count < COUNT_W'(MIN_SAMPLES)) begin
      n_eff = CW'(MIN_SAMPLES);
    end else if (int'(sample_count) > MAX_SAMPLES) begin
      n_eff = CW'(MAX_SAMPLES);
    end else begin
      n_eff = CW'(sample_count);
    end
  end

  always_comb begin
    pos         = (filled >= CW'(MAX_SAMPLES - 1)) ? CW'(MAX_SAMPLES - 1) : filled;
    pos_inc     = pos + CW'(1);
    last        = (pos_inc >= n_eff);
    filled_next = last ? '0 : pos_inc;
  end

  assign sample_ready = !q_full && !rst;
  assign q_push       = sample_valid && sample_ready;

  always_comb begin
    q_word.sample = sample;
    q_word.pos    = POS_W'(pos);
    q_word.idx    = POS_W'(n_eff >> 1);
    q_word.last   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= COUNT_RESET;
      filled       <= '0;
    end else begin
      if (cfg_wr_en) begin
        sample_count <= cfg_wr_data;
      end
      if (q_push) begin
        filled <= filled_next;
      end
    end
  end

endmodule

FILE: rtl/mns_queue.sv
module mns_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mns_pkg::mns_word_t push_word,
  output logic               full,
  input  logic               pop,
  output logic               rd_valid,
  output mns_pkg::mns_word_t rd_word
);
  import mns_pkg::*;

  mns_word_t          entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_word  = entry[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/mns_back.sv
module mns_back #(
  parameter int MAX_SAMPLES = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  mns_pkg::mns_word_t                  q_word,
  output logic                                q_pop,
  output logic                                median_valid,
  input  logic                                median_ready,
  output logic signed [mns_pkg::SAMPLE_W-1:0] median
);
  import mns_pkg::*;

  localparam int IW = $clog2(MAX_SAMPLES);

  logic signed [SAMPLE_W-1:0] slot [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0]     gt;
  logic [MAX_SAMPLES-1:0]     live;
  logic [MAX_SAMPLES-1:0]     in_reach;
  logic [IW-1:0]              p;
  logic                       pend;
  logic [IW-1:0]              rd_idx;
  logic                       out_free;

  assign p        = q_word.pos[IW-1:0];
  assign out_free = !median_valid || median_ready;
  // a finished block must be read out before the cells change again
  assign q_pop    = q_valid && (!pend || out_free);

  // sorted insertion cells: larger entries move up one, sample drops in the gap
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_slot
    assign gt[i]       = (slot[i] > q_word.sample);
    assign live[i]     = ((IW+1)'(i) <  {1'b0, p});
    assign in_reach[i] = ((IW+1)'(i) <= {1'b0, p});

    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (q_pop && in_reach[i] && !(live[i] && !gt[i])) begin
          slot[i] <= q_word.sample;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (q_pop && in_reach[i] && !(live[i] && !gt[i])) begin
          slot[i] <= (live[i-1] && gt[i-1]) ? slot[i-1] : q_word.sample;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend && out_free) begin
      median <= slot[rd_idx];
    end
    if (q_pop && q_word.last) begin
      rd_idx <= q_word.idx[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend         <= 1'b0;
      median_valid <= 1'b0;
    end else begin
      if (pend && out_free) begin
        median_valid <= 1'b1;
      end else if (median_ready) begin
        median_valid <= 1'b0;
      end
      if (q_pop && q_word.last) begin
        pend <= 1'b1;
      end else if (pend && out_free) begin
        pend <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/median_of_n_samples_unit.sv
// median of a block of n signed 24-bit converter samples
// input channel: sample_valid / sample_ready carry one sample word per transfer
// output channel: median_valid / median_ready carry one median word per block
// config: cfg_wr_en writes cfg_wr_data into sample_count (reset 3); counts below 3
//   act as 3 and counts above MAX_SAMPLES act as MAX_SAMPLES; write only while idle
// the front keeps the block fill count and tags each word with its slot and whether
//   it closes the block; a two-word queue hands words to the back
// the back is a row of sorted insertion cells, one sample placed per cycle, so the
//   sustained rate is one sample per clock unless a finished median awaits the receiver
// the median is registered in steps: the closing word is written into the queue,
//   inserted into the cells, then the median is read into the output register
// when the receiver stalls the median holds in its output register; the cells keep
//   taking the next block's samples until a second block completes, then the back
//   and queue fill and sample_ready drops
// reset (rst, synchronous): clears the fill count, the queue, any pending median and
//   sets sample_count to 3; cell contents are not cleared and never read unwritten
module median_of_n_samples_unit #(
  parameter int MAX_SAMPLES = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [mns_pkg::COUNT_W-1:0]         cfg_wr_data,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  logic signed [mns_pkg::SAMPLE_W-1:0] sample,
  output logic                                median_valid,
  input  logic                                median_ready,
  output logic signed [mns_pkg::SAMPLE_W-1:0] median
);
  import mns_pkg::*;

  // front to queue
  logic      q_push;
  logic      q_full;
  mns_word_t q_wr_word;

  // queue to back
  logic      q_valid;
  logic      q_pop;
  mns_word_t q_rd_word;

  mns_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_word       (q_wr_word)
  );

  mns_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_wr_word),
    .full      (q_full),
    .pop       (q_pop),
    .rd_valid  (q_valid),
    .rd_word   (q_rd_word)
  );

  mns_back #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_word       (q_rd_word),
    .q_pop        (q_pop),
    .median_valid (median_valid),
    .median_ready (median_ready),
    .median       (median)
  );

endmodule

FILE: rtl/mns_checker.sv
module mns_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                sample_valid,
  input logic                                sample_ready,
  input logic                                median_valid,
  input logic                                median_ready,
  input logic signed [mns_pkg::SAMPLE_W-1:0] median
);

  // a stalled median word holds
  a_median_hold: assert property (@(posedge clk) disable iff (rst)
    median_valid && !median_ready |=> median_valid && $stable(median))
    else $error("median word changed or dropped while stalled");

  // reset empties the output
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !median_valid)
    else $error("median_valid high after reset");

  // no input word is taken during reset
  a_no_accept_in_reset: assert property (@(posedge clk)
    rst |-> !(sample_valid && sample_ready))
    else $error("sample word accepted during reset");

  // a median needs a whole block through the queue, cells and output register after reset
  a_median_after_reset: assert property (@(posedge clk)
    $rose(median_valid) |-> !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3))
    else $error("median word too soon after reset");

endmodule

bind median_of_n_samples_unit mns_checker u_mns_checker (.*);

FILE: verif/median_of_n_samples_unit_test.sv
module median_of_n_samples_unit_test;
  import mns_pkg::*;

  localparam int MAX_SAMPLES = 32;
  // settling margin for the count-write and drain waits
  localparam int LATENCY = 2;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SAMPLE_TARGET = 1750;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -24'sh800000;
  localparam logic [COUNT_W-1:0] COUNT_ALL_ONES = '1;

  // running model of the block: sorted insertion plus fill count, and the
  // medians it owes the output side in order
  class median_tracker;
    logic signed [SAMPLE_W-1:0] held [MAX_SAMPLES];
    int fill;
    logic [COUNT_W-1:0] count_reg;
    logic signed [SAMPLE_W-1:0] owed_medians [$];
    int mismatches;
    int checked;

    function new();
      fill = 0;
      count_reg = COUNT_RESET;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_count(logic [COUNT_W-1:0] v);
      count_reg = v;
    endfunction

    function int pending();
      return owed_medians.size();
    endfunction

    // note an accepted sample word, owe a median when the block closes
    function void take_sample(logic signed [SAMPLE_W-1:0] s);
      int n;
      int pos;
      n = int'(count_reg);
      if (n < MIN_SAMPLES) n = MIN_SAMPLES;
      if (n > MAX_SAMPLES) n = MAX_SAMPLES;
      pos = fill;
      while (pos > 0 && held[pos-1] > s) begin
        held[pos] = held[pos-1];
        pos--;
      end
      held[pos] = s;
      fill++;
      // a count lowered mid-block closes the block on the next sample
      if (fill >= n) begin
        owed_medians.push_back(held[n/2]);
        fill = 0;
      end
    endfunction

    function void check_median(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      checked++;
      if (owed_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("median %0d arrived with none owed", got);
      end else begin
        want = owed_medians.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("median mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;
  logic sample_valid = 1'b0;
  logic sample_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic median_valid;
  logic median_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] median;

  median_tracker board = new();

  // idling knobs, changed per phase by the stimulus process
  bit send_gaps_on = 1'b0;
  bit recv_stalls_on = 1'b0;
  int recv_stall_left = 0;
  int cycle_count = 0;
  int samples_sent = 0;
  int count_writes = 0;

  median_of_n_samples_unit #(.MAX_SAMPLES(MAX_SAMPLES)) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .median_valid (median_valid),
    .median_ready (median_ready),
    .median       (median)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // gap length: one draw in ten takes the long range, the rest the short range
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  // output side: check each median word taken, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst && median_valid && median_ready)
      board.check_median(median);
    if (recv_stall_left > 0) begin
      recv_stall_left--;
      median_ready <= 1'b0;
    end else if (recv_stalls_on && $urandom_range(0, 3) == 0) begin
      recv_stall_left = idle_len() - 1;
      median_ready <= 1'b0;
    end else begin
      median_ready <= 1'b1;
    end
  end

  // present one sample word and hold it until it is taken
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
    sample_valid <= 1'b1;
    sample <= v;
    do @(posedge clk); while (!sample_ready);
    board.take_sample(v);
    samples_sent++;
  endtask

  // random gap between words on the input side
  task automatic send_gap();
    int len;
    len = 0;
    if (send_gaps_on && $urandom_range(0, 2) == 0)
      len = idle_len();
    if (len > 0) begin
      sample_valid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // count register write: only once every owed median is out and any
  // word that closes no block has had time to settle into the cells
  task automatic write_count(input logic [COUNT_W-1:0] v);
    sample_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.write_count(v);
    count_writes++;
  endtask

  // random sample: full range mostly, plus extremes and a narrow band for ties
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_W'($signed($urandom_range(0, 8)) - 4);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // count for a phase: small blocks mostly, sometimes the low clamp, a mid size or the top
  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return COUNT_W'($urandom_range(0, 2));
      1: return COUNT_W'($urandom_range(MAX_SAMPLES, 63));
      2: return COUNT_W'($urandom_range(9, 31));
      default: return COUNT_W'($urandom_range(3, 8));
    endcase
  endfunction

  initial begin
    int phase_len;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset count of 3 with the field extremes
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(-24'sd1);
    send_sample(24'sd1);
    send_sample(SAMPLE_MAX);
    // equal samples
    send_sample(24'sd5);
    send_sample(24'sd5);
    send_sample(24'sd5);
    // zero count acts as three
    write_count('0);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    // even count gives the upper median
    write_count(COUNT_W'(4));
    send_sample(24'sd4);
    send_sample(24'sd1);
    send_sample(24'sd3);
    send_sample(24'sd2);
    // count lowered while the block already holds more than the new count
    write_count(COUNT_W'(8));
    send_sample(24'sd50);
    send_sample(-24'sd20);
    send_sample(24'sd7);
    send_sample(SAMPLE_MAX);
    send_sample(-24'sd3);
    write_count(COUNT_W'(3));
    send_sample(24'sd0);
    // all ones in the register acts as the maximum block
    write_count(COUNT_ALL_ONES);
    write_count(COUNT_W'(MAX_SAMPLES));
    write_count(COUNT_W'(1));

    // random phases, each with its own count and idling pattern; a phase may
    // end mid-block so the next count write lands on a partly filled block
    while (samples_sent < SAMPLE_TARGET) begin
      write_count(pick_count());
      send_gaps_on = ($urandom_range(0, 3) != 0);
      recv_stalls_on = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) begin
        send_sample(pick_sample());
        send_gap();
      end
    end

    // drain: hold off the input until every owed median has come
    sample_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY * 4) @(posedge clk);

    $display("covered %0d samples in blocks of 3 to %0d, %0d count writes from 0 to 63",
             samples_sent, MAX_SAMPLES, count_writes);
    $display("checked %0d medians with random gaps and output stalls", board.checked);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
